FILE: rtl/modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

  // Fixed widths of the item fields and the register port
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd1;

  // Register reset values
  localparam logic [DATA_W-1:0] EXPONENT_RST = 32'd1;
  localparam logic [DATA_W-1:0] MODULUS_RST  = 32'd2;

  // Microprogram addresses
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;  // wait for an item, load operands
  localparam step_t STEP_BASE  = 3'd1;  // stage message for the first reduction
  localparam step_t STEP_RBASE = 3'd2;  // reduce message mod modulus
  localparam step_t STEP_WBASE = 3'd3;  // base register takes the reduced message
  localparam step_t STEP_MUL   = 3'd4;  // acc*base and base*base
  localparam step_t STEP_RED   = 3'd5;  // bit-serial reduction of both products
  localparam step_t STEP_WB    = 3'd6;  // commit one exponent bit
  localparam step_t STEP_DONE  = 3'd7;  // hand the result to the output register

  // Jump conditions; the jump is taken when the condition holds,
  // otherwise the step counter advances by one
  typedef enum logic [2:0] {
    COND_NONE      = 3'd0,
    COND_NO_ITEM   = 3'd1,
    COND_CNT_NZ    = 3'd2,
    COND_MORE_BITS = 3'd3,
    COND_OUT_BUSY  = 3'd4
  } cond_t;

  // One control word
  typedef struct packed {
    logic  ld_item;   // load operands on an accepted item
    logic  mul_en;    // register the two products
    logic  sq_one;    // square lane multiplies by one
    logic  red_en;    // one reduction step on both lanes
    logic  wb_base;   // base register takes the square lane remainder
    logic  wb_bit;    // commit one exponent bit
    logic  emit;      // write the output register
    cond_t cond;
    step_t target;
  } uc_word_t;

  // Microprogram ROM
  function automatic uc_word_t uc_rom(input step_t step);
    uc_word_t w;
    w = '{default: '0, cond: COND_NONE};
    case (step)
      STEP_IDLE: begin
        w.ld_item = 1'b1;
        w.cond    = COND_NO_ITEM;
        w.target  = STEP_IDLE;
      end
      STEP_BASE: begin
        w.mul_en = 1'b1;
        w.sq_one = 1'b1;
      end
      STEP_RBASE: begin
        w.red_en = 1'b1;
        w.cond   = COND_CNT_NZ;
        w.target = STEP_RBASE;
      end
      STEP_WBASE: begin
        w.wb_base = 1'b1;
      end
      STEP_MUL: begin
        w.mul_en = 1'b1;
      end
      STEP_RED: begin
        w.red_en = 1'b1;
        w.cond   = COND_CNT_NZ;
        w.target = STEP_RED;
      end
      STEP_WB: begin
        w.wb_bit = 1'b1;
        w.cond   = COND_MORE_BITS;
        w.target = STEP_MUL;
      end
      STEP_DONE: begin
        // falls through to step zero by counter wrap
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_DONE;
      end
      default: begin
        w.cond   = COND_NONE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none

// Modular exponentiation: out_power_result = in_message ^ exponent mod modulus.
// Registers: index 0 is the exponent (reset 1), index 1 the modulus (reset 2),
// written through cfg_we / cfg_index / cfg_data; the user must write them only
// while the block is idle. Only the low WORD_BITS bits of message, exponent
// and modulus are used. A modulus of 0 or 1 yields 0.
// Input channel: an item is taken when in_valid is high and in_stall low.
// in_stall is low only while the sequencer sits at its idle step.
// Output channel: one result per item, held in an output register until
// out_valid is high and out_stall low; it does not change while stalled.
// From accept to out_valid the sequencer loads the operands, reduces the
// message, then for each exponent bit forms both products and reduces them
// bit-serially, one restoring step per product bit, both side by side.
// A new item can be taken in the cycle after the result is loaded; none is
// taken while an earlier item is still being worked on.
// If the output register is still full, the sequencer waits at its last
// step until the result is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle, drops
// out_valid and restores the register defaults.
module modular_exponentiation #(
  parameter int WORD_BITS = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // configuration
  input  wire                               cfg_we,
  input  wire [modexp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [modexp_pkg::DATA_W-1:0]      cfg_data,
  // input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [modexp_pkg::DATA_W-1:0]      in_message,
  // result channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [modexp_pkg::DATA_W-1:0]     out_power_result
);

  import modexp_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int PW     = 2 * WORD_BITS;
  localparam int CNT_W  = $clog2(PW);
  localparam int IDX_W  = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(PW - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WORD_BITS - 1);

  // Configuration registers
  logic [DATA_W-1:0] exponent_r;
  logic [DATA_W-1:0] modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= EXPONENT_RST;
      modulus_r  <= MODULUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPONENT: exponent_r <= cfg_data;
        REG_MODULUS:  modulus_r  <= cfg_data;
        default:      ;
      endcase
    end
  end

  logic [W-1:0] mod_w;
  logic         mod_small;
  assign mod_w     = modulus_r[W-1:0];
  assign mod_small = (mod_w < W'(2));

  // Sequencer
  step_t    pc_r, pc_nxt;
  uc_word_t uc;
  logic     in_accept;
  logic     out_busy;
  logic     take;
  logic     emit;

  // Datapath registers
  logic [W-1:0]     acc_r, sq_r;
  logic [W-1:0]     exp_sh_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PW-1:0]    prod_a_r, prod_s_r;
  logic [W-1:0]     rem_a_r, rem_s_r;
  logic             out_valid_r;
  logic [DATA_W-1:0] out_res_r;

  assign uc        = uc_rom(pc_r);
  assign in_stall  = (pc_r != STEP_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_busy  = out_valid_r && out_stall;
  assign emit      = uc.emit && !out_busy;

  // Jump condition and next step
  always_comb begin
    case (uc.cond)
      COND_NONE:      take = 1'b0;
      COND_NO_ITEM:   take = !in_accept;
      COND_CNT_NZ:    take = (cnt_r != '0);
      COND_MORE_BITS: take = (idx_r != IDX_LAST);
      COND_OUT_BUSY:  take = out_busy;
      default:        take = 1'b0;
    endcase
    pc_nxt = take ? uc.target : STEP_W'(pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Products of the two lanes
  logic [PW-1:0] mul_a, mul_s;
  assign mul_a = PW'(acc_r) * PW'(sq_r);
  assign mul_s = uc.sq_one ? PW'(sq_r) : PW'(sq_r) * PW'(sq_r);

  // One restoring step per lane: shift in the product MSB, subtract if it fits
  logic [W:0]   trial_a, trial_s;
  logic [W:0]   diff_a, diff_s;
  logic [W-1:0] rem_a_nxt, rem_s_nxt;

  always_comb begin
    trial_a   = {rem_a_r, prod_a_r[PW-1]};
    trial_s   = {rem_s_r, prod_s_r[PW-1]};
    diff_a    = trial_a - {1'b0, mod_w};
    diff_s    = trial_s - {1'b0, mod_w};
    rem_a_nxt = (trial_a >= {1'b0, mod_w}) ? diff_a[W-1:0] : trial_a[W-1:0];
    rem_s_nxt = (trial_s >= {1'b0, mod_w}) ? diff_s[W-1:0] : trial_s[W-1:0];
  end

  // Operand, product and remainder registers
  always_ff @(posedge clk) begin
    if (uc.ld_item && in_accept) begin
      acc_r    <= W'(1);
      sq_r     <= in_message[W-1:0];
      exp_sh_r <= exponent_r[W-1:0];
      idx_r    <= '0;
    end
    if (uc.mul_en) begin
      prod_a_r <= mul_a;
      prod_s_r <= mul_s;
      rem_a_r  <= '0;
      rem_s_r  <= '0;
      cnt_r    <= CNT_LOAD;
    end
    if (uc.red_en) begin
      prod_a_r <= {prod_a_r[PW-2:0], 1'b0};
      prod_s_r <= {prod_s_r[PW-2:0], 1'b0};
      rem_a_r  <= rem_a_nxt;
      rem_s_r  <= rem_s_nxt;
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (uc.wb_base) begin
      sq_r <= rem_s_r;
    end
    if (uc.wb_bit) begin
      if (exp_sh_r[0]) begin
        acc_r <= rem_a_r;
      end
      sq_r     <= rem_s_r;
      exp_sh_r <= exp_sh_r >> 1;
      idx_r    <= idx_r + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= mod_small ? '0 : DATA_W'(acc_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_res_r;

  // An accepted item starts the program at its first working step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> pc_r == STEP_BASE)
    else $error("accepted item did not start the sequence");

  // The reduction loop leaves once its count is spent
  a_red_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_RED && cnt_r == '0) |=> pc_r == STEP_WB)
    else $error("reduction loop did not exit");

  // After the last exponent bit the program goes to the result step
  a_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_WB && idx_r == IDX_LAST) |=> pc_r == STEP_DONE)
    else $error("exponent scan did not end at the last bit");

  // A result written to the output register is offered on the next cycle
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid && pc_r == STEP_IDLE)
    else $error("result not presented after emit");

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import modexp_pkg::*;

  // One row of the directed table
  typedef struct {
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] message;
    bit                known;
    logic [DATA_W-1:0] result;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_message;
  logic                 out_valid;
  logic                 out_stall;
  logic [DATA_W-1:0]    out_power_result;

  // Expected power results, oldest first
  logic [DATA_W-1:0] power_q[$];
  dir_row_t          dir_rows[$];
  int                fail_count;
  int                send_idle;
  int                recv_idle;

  // Register copies as the block should hold them
  logic [DATA_W-1:0] cur_exponent;
  logic [DATA_W-1:0] cur_modulus;

  modular_exponentiation uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_message       (in_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Right-to-left square-and-multiply; modulus below two gives zero
  function automatic logic [DATA_W-1:0] mod_power(input logic [DATA_W-1:0] msg,
                                                  input logic [DATA_W-1:0] e,
                                                  input logic [DATA_W-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m64;
    if (m < 2) return '0;
    if (e == 0) return DATA_W'(1);
    m64 = {32'd0, m};
    acc = 64'd1;
    sq  = {32'd0, msg} % m64;
    for (int i = 0; i < DATA_W; i++) begin
      if (e[i]) acc = (acc * sq) % m64;
      sq = (sq * sq) % m64;
    end
    return acc[DATA_W-1:0];
  endfunction

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Result checker
  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (power_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %h", $time, out_power_result);
        fail_count++;
      end else begin
        want = power_q.pop_front();
        if (out_power_result !== want) begin
          $display("%0t: power_result mismatch, expected %h, got %h",
                   $time, want, out_power_result);
          fail_count++;
        end
      end
    end
  end

  task automatic add_row(input logic [DATA_W-1:0] e, input logic [DATA_W-1:0] m,
                         input logic [DATA_W-1:0] msg, input bit known,
                         input logic [DATA_W-1:0] res);
    dir_row_t r;
    r.exponent = e;
    r.modulus  = m;
    r.message  = msg;
    r.known    = known;
    r.result   = res;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Hold off the sender until every expected item has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (power_q.size() != 0);
  endtask

  // Write both registers; only called with the block idle
  task automatic set_config(input logic [DATA_W-1:0] e, input logic [DATA_W-1:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_EXPONENT;
    cfg_data  <= e;
    @(posedge clk);
    cfg_index <= REG_MODULUS;
    cfg_data  <= m;
    @(posedge clk);
    cfg_we       <= 1'b0;
    cur_exponent = e;
    cur_modulus  = m;
  endtask

  // Offer one item, hold it until taken, then log what should come back
  task automatic send_msg(input logic [DATA_W-1:0] msg, input logic [DATA_W-1:0] want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_message <= msg;
    do @(posedge clk); while (in_stall);
    power_q.insert(power_q.size(), want);
  endtask

  initial begin
    dir_row_t          row;
    logic [DATA_W-1:0] e_pick;
    logic [DATA_W-1:0] m_pick;
    logic [DATA_W-1:0] msg_pick;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_EXPONENT;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_message <= '0;
    out_stall  <= 1'b0;
    fail_count   = 0;
    send_idle    = 29;
    recv_idle    = 87;
    cur_exponent = EXPONENT_RST;
    cur_modulus  = MODULUS_RST;

    // Register defaults first, then the corner cases
    add_row(EXPONENT_RST, MODULUS_RST, 32'd5, 1'b1, 32'd1);
    add_row(EXPONENT_RST, MODULUS_RST, 32'd0, 1'b1, 32'd0);
    add_row(EXPONENT_RST, MODULUS_RST, 32'hFFFF_FFFF, 1'b1, 32'd1);
    // zero exponent
    add_row(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd1);
    add_row(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1);
    // modulus below two, even with a zero exponent
    add_row(32'd5, 32'd0, 32'd7, 1'b1, 32'd0);
    add_row(32'd0, 32'd1, 32'd3, 1'b1, 32'd0);
    add_row(32'd5, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0);
    // message at, just below or above the modulus
    add_row(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0);
    add_row(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE);
    add_row(32'd3, 32'd2, 32'd3, 1'b1, 32'd1);
    // full-width exponent
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'd1);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 1'b0, '0);
    // largest 32-bit prime modulus
    add_row(32'd2, 32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b1, 32'd16);
    add_row(32'd2, 32'hFFFF_FFFB, 32'h8000_0000, 1'b0, '0);
    // textbook RSA pair, 61 * 53, then two more wide-exponent rows
    add_row(32'd17, 32'd3233, 32'd65, 1'b1, 32'd2790);
    add_row(32'd2753, 32'd3233, 32'd2790, 1'b1, 32'd65);
    add_row(32'h8000_0000, 32'hFFFF_FFFF, 32'd3, 1'b0, '0);
    add_row(32'h8000_0001, 32'hFFFF_FFFE, 32'hDEAD_BEEF, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.exponent !== cur_exponent || row.modulus !== cur_modulus)
        set_config(row.exponent, row.modulus);
      send_msg(row.message,
               row.known ? row.result : mod_power(row.message, cur_exponent, cur_modulus));
    end

    // Random phases: fresh registers each phase, three idle patterns
    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle = 29;
          recv_idle = 87;
        end
        1: begin
          send_idle = 87;
          recv_idle = 29;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase

      case ($urandom_range(4))
        0, 1: e_pick = $urandom;
        2: e_pick = $urandom_range(16);
        3: e_pick = 32'hFFFF_FFFF;
        default: e_pick = 32'd1 << $urandom_range(31);
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: e_pick = e_pick;
        default: e_pick = e_pick;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: m_pick = $urandom | 32'h8000_0000;
        4, 5: m_pick = $urandom_range(2, 1000);
        6: m_pick = 32'hFFFF_FFFF;
        7: m_pick = 32'hFFFF_FFFB;
        8: m_pick = $urandom_range(1);
        default: m_pick = $urandom_range(2, 32'h00FF_FFFF);
      endcase
      set_config(e_pick, m_pick);

      for (int k = 0; k < 30; k++) begin
        case ($urandom_range(3))
          0, 1: msg_pick = $urandom;
          2: msg_pick = (cur_modulus >= 2) ? $urandom % cur_modulus : $urandom;
          default: msg_pick = cur_modulus + $urandom_range(2) - 1;
        endcase
        send_msg(msg_pick, mod_power(msg_pick, cur_exponent, cur_modulus));
        // now and then let the block run dry before the next item
        if ($urandom_range(19) == 0) drain();
      end
    end

    drain();
    // catch any stray item after the last one
    repeat (2300) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/modexp_pkg.sv
rtl/modular_exponentiation.sv
verif/tb.sv
